/* rtl/annexb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_pkg
// Shared constants and types of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package annexb_pkg;

  // width of the byte position counter (16..32)
  localparam int unsigned POS_BITS  = 24;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned SAMPLE_W  = 26;
  localparam int unsigned TYPE_W    = 5;
  localparam int unsigned SUM_W     = ((POS_BITS > SAMPLE_W) ? POS_BITS : SAMPLE_W) + 2;
  localparam int unsigned TDATA_W   = 88;

  // last usable position plus one: a byte arriving here overflows
  localparam logic [POS_BITS-1:0] POS_LIMIT = '1;

  localparam logic [TYPE_W-1:0] TYPE_SPS = 5'd7;
  localparam logic [TYPE_W-1:0] TYPE_PPS = 5'd8;
  localparam logic [TYPE_W-1:0] TYPE_AUD = 5'd9;
  localparam logic [2:0]        PREFIX_BYTES = 3'd4;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [1:0] {
    CLS_SPS = 2'd0,
    CLS_PPS = 2'd1,
    CLS_AUD = 2'd2,
    CLS_PIC = 2'd3
  } unit_class_e;

  // one queue entry: a closed unit, an access unit end, or both
  typedef struct packed {
    logic                has_desc;
    logic                has_sum;
    logic                ovf;
    logic [TYPE_W-1:0]   utype;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] len;
  } event_t;

  typedef struct packed {
    logic                item_kind;
    logic                last;
    logic                ovf;
    logic                params;
    logic [SAMPLE_W-1:0] sample;
    logic [OUT_W-1:0]    length;
    logic [OUT_W-1:0]    offset;
    logic [TYPE_W-1:0]   utype;
    unit_class_e         cls;
  } result_t;

endpackage
`default_nettype wire

/* rtl/annexb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_front
// Byte scanner: start code search, position tracking, unit boundaries.
// ----------------------------------------------------------------------------
module annexb_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // data_byte
  input  wire logic                 s_axis_tlast_i,   // end_of_unit
  input  wire logic                 full_i,
  output logic                      push_o,
  output annexb_pkg::event_t        event_o
);
  import annexb_pkg::*;

  logic                inside_q, inside_d;
  logic                ovf_q, ovf_d;
  logic [1:0]          zr_q, zr_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [POS_BITS-1:0] end_q, end_d;
  logic [TYPE_W-1:0]   type_q, type_d;

  logic                accept, active, hit_limit, start_code;
  logic                close_old, close_new;
  logic [POS_BITS-1:0] pos_inc;
  logic [7:0]          b;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = ~full_i;
  assign accept          = s_axis_tvalid_i & ~full_i;
  assign active          = ~ovf_q & (pos_q != POS_LIMIT);
  assign hit_limit       = ~ovf_q & (pos_q == POS_LIMIT);
  assign start_code      = active & (zr_q == 2'd2) & (b == 8'd1);
  assign pos_inc         = pos_q + 1'b1;

  always_comb begin
    inside_d = inside_q;
    ovf_d    = ovf_q;
    zr_d     = zr_q;
    pos_d    = pos_q;
    start_d  = start_q;
    end_d    = end_q;
    type_d   = type_q;
    if (hit_limit) begin
      ovf_d    = 1'b1;
      inside_d = 1'b0;
    end else if (start_code) begin
      inside_d = 1'b1;
      start_d  = pos_inc;
      end_d    = pos_inc;
      type_d   = '0;
      zr_d     = 2'd0;
    end else if (active) begin
      if (inside_q) begin
        if (pos_q == start_q) type_d = b[TYPE_W-1:0];
        if (b != 8'd0) end_d = pos_inc;
      end
      if (b == 8'd0) begin
        zr_d = (zr_q == 2'd2) ? 2'd2 : zr_q + 2'd1;
      end else begin
        zr_d = 2'd0;
      end
    end
    if (active) pos_d = pos_inc;
  end

  // a start code closes the unit that was open; end of access unit closes the new state
  assign close_old = inside_q & (end_q != start_q);
  assign close_new = inside_d & (end_d != start_d) & ~ovf_d;

  always_comb begin
    event_o.has_sum  = s_axis_tlast_i;
    event_o.ovf      = ovf_d;
    event_o.has_desc = start_code ? close_old : (s_axis_tlast_i & close_new);
    event_o.utype    = start_code ? type_q : type_d;
    event_o.start    = start_code ? start_q : start_d;
    event_o.len      = start_code ? (end_q - start_q) : (end_d - start_d);
  end

  assign push_o = accept & (event_o.has_desc | event_o.has_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      ovf_q    <= 1'b0;
      zr_q     <= 2'd0;
      pos_q    <= '0;
      start_q  <= '0;
      end_q    <= '0;
      type_q   <= '0;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        inside_q <= 1'b0;
        ovf_q    <= 1'b0;
        zr_q     <= 2'd0;
        pos_q    <= '0;
        start_q  <= '0;
        end_q    <= '0;
        type_q   <= '0;
      end else begin
        inside_q <= inside_d;
        ovf_q    <= ovf_d;
        zr_q     <= zr_d;
        pos_q    <= pos_d;
        start_q  <= start_d;
        end_q    <= end_d;
        type_q   <= type_d;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/annexb_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_fifo
// Short event queue between the byte scanner and the result stage.
// ----------------------------------------------------------------------------
module annexb_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire annexb_pkg::event_t data_i,
  input  wire logic               pop_i,
  output annexb_pkg::event_t      data_o,
  output logic                    valid_o,
  output logic                    full_o
);
  import annexb_pkg::*;

  event_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/annexb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_back
// Result stage: unit classification, sample size total, output register.
// ----------------------------------------------------------------------------
module annexb_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire annexb_pkg::event_t            event_i,
  input  wire logic                          valid_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // unit_class, unit_type, payload_offset, payload_length, sample_length,
  // params_seen, overflow, zero fill
  output logic [annexb_pkg::TDATA_W-1:0]     m_axis_tdata_o,
  output logic [0:0]                         m_axis_tuser_o,  // item_kind
  output logic                               m_axis_tlast_o   // last
);
  import annexb_pkg::*;

  logic                out_valid_q;
  result_t             res_q, res_d;
  logic [SAMPLE_W-1:0] total_q, total_d;
  logic                params_q, params_d;
  logic                phase_q, phase_d;

  logic                load, step, emit_desc;
  unit_class_e         cls;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] sum_sat;

  assign load      = ~out_valid_q | m_axis_tready_i;
  assign step      = valid_i & load;
  assign emit_desc = event_i.has_desc & ~phase_q;
  // a unit closed on the final byte gives two results: descriptor, then summary
  assign pop_o     = step & ~(emit_desc & event_i.has_sum);

  always_comb begin
    unique case (event_i.utype)
      TYPE_SPS: cls = CLS_SPS;
      TYPE_PPS: cls = CLS_PPS;
      TYPE_AUD: cls = CLS_AUD;
      default:  cls = CLS_PIC;
    endcase
  end

  assign sum     = SUM_W'(total_q) + SUM_W'(event_i.len) + SUM_W'(PREFIX_BYTES);
  assign sum_sat = (sum[SUM_W-1:SAMPLE_W] != '0) ? '1 : sum[SAMPLE_W-1:0];

  always_comb begin
    total_d  = total_q;
    params_d = params_q;
    phase_d  = phase_q;
    res_d    = '0;
    if (emit_desc) begin
      res_d.item_kind = 1'b0;
      res_d.cls       = cls;
      res_d.utype     = event_i.utype;
      res_d.offset    = OUT_W'(event_i.start);
      res_d.length    = OUT_W'(event_i.len);
      if (cls == CLS_PIC) total_d = sum_sat;
      if ((cls == CLS_SPS) || (cls == CLS_PPS)) params_d = 1'b1;
      if (event_i.has_sum) phase_d = 1'b1;
    end else begin
      res_d.item_kind = 1'b1;
      res_d.last      = 1'b1;
      res_d.sample    = total_q;
      res_d.params    = params_q;
      res_d.ovf       = event_i.ovf;
      total_d         = '0;
      params_d        = 1'b0;
      phase_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
      params_q    <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) out_valid_q <= step;
      if (step) begin
        total_q  <= total_d;
        params_q <= params_d;
        phase_q  <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.item_kind;
  assign m_axis_tlast_o  = res_q.last;
  assign m_axis_tdata_o  = {5'd0, res_q.ovf, res_q.params, res_q.sample, res_q.length,
                            res_q.offset, res_q.utype, res_q.cls};

endmodule
`default_nettype wire

/* rtl/annexb_nal_unit_splitter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_top
// Splits an Annex B access unit into NAL unit descriptors and a summary.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the scanner stalls only when the 4-entry
//   event queue is full.
// Path: a result is held in the event queue, then in the output register.
//   A byte that closes a unit and ends the access unit gives two results,
//   the descriptor first and then the summary.
// Reset: asynchronous, clears all control state; no clearing pass.
module annexb_nal_unit_splitter_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [7:0]                s_axis_tdata_i,   // data_byte
  input  wire logic                      s_axis_tlast_i,   // end_of_unit
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // [1:0] unit_class, [6:2] unit_type, [30:7] payload_offset,
  // [54:31] payload_length, [80:55] sample_length, [81] params_seen,
  // [82] overflow, [87:83] zero
  output logic [annexb_pkg::TDATA_W-1:0] m_axis_tdata_o,
  output logic [0:0]                     m_axis_tuser_o,   // item_kind
  output logic                           m_axis_tlast_o    // last
);
  import annexb_pkg::*;

  event_t ev_in, ev_out;
  logic   push, pop, full, ev_valid;

  annexb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .full_i          (full),
    .push_o          (push),
    .event_o         (ev_in)
  );

  annexb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ev_in),
    .pop_i   (pop),
    .data_o  (ev_out),
    .valid_o (ev_valid),
    .full_o  (full)
  );

  annexb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .event_i         (ev_out),
    .valid_i         (ev_valid),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire
